### rtl/tbg_pkg.sv
// Shared constants and types for the table waveform generator.
// No dependencies; the core and checker reference it by scoped names.
package tbg_pkg;

  localparam int unsigned DepthDefault      = 600;
  localparam int unsigned SampleBitsDefault = 12;

  localparam int unsigned CodeW   = 12;
  localparam int unsigned AddrW   = 10;
  localparam int unsigned KeyW    = 4;
  localparam int unsigned OpW     = 2;
  localparam int unsigned SelW    = 2;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned StrideW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned PctScale = 100;

  localparam logic [CodeW-1:0] SqLowReset  = 12'd124;
  localparam logic [CodeW-1:0] SqHighReset = 12'd3636;

  localparam logic [DutyW-1:0]   DutyReset = 7'd50;
  localparam logic [DutyW-1:0]   DutyStep  = 7'd10;
  localparam logic [DutyW-1:0]   DutyMin   = 7'd10;
  localparam logic [DutyW-1:0]   DutyMax   = 7'd90;
  localparam logic [StrideW-1:0] StrideOne = 3'd1;

  typedef enum logic [OpW-1:0] {
    OP_TICK = 2'd0,
    OP_KEY  = 2'd1,
    OP_LOAD = 2'd2
  } op_e;

  typedef enum logic [SelW-1:0] {
    SEL_SINE     = 2'd0,
    SEL_RAMP     = 2'd1,
    SEL_TRIANGLE = 2'd2
  } table_sel_e;

  typedef enum logic [1:0] {
    WAVE_SQUARE   = 2'd0,
    WAVE_SINE     = 2'd1,
    WAVE_RAMP     = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SQ_LOW  = 1'b0,
    CFG_SQ_HIGH = 1'b1
  } cfg_idx_e;

  localparam logic [KeyW-1:0] KEY_DUTY_RESET = 4'h0;
  localparam logic [KeyW-1:0] KEY_STRIDE1    = 4'h1;
  localparam logic [KeyW-1:0] KEY_STRIDE2    = 4'h2;
  localparam logic [KeyW-1:0] KEY_STRIDE3    = 4'h3;
  localparam logic [KeyW-1:0] KEY_STRIDE4    = 4'h4;
  localparam logic [KeyW-1:0] KEY_STRIDE5    = 4'h5;
  localparam logic [KeyW-1:0] KEY_SINE       = 4'h6;
  localparam logic [KeyW-1:0] KEY_TRIANGLE   = 4'h7;
  localparam logic [KeyW-1:0] KEY_RAMP       = 4'h8;
  localparam logic [KeyW-1:0] KEY_SQUARE     = 4'h9;
  localparam logic [KeyW-1:0] KEY_DUTY_DOWN  = 4'hA;
  localparam logic [KeyW-1:0] KEY_DUTY_UP    = 4'hB;

endpackage

### rtl/tbg_store.sv
// Single waveform store: one write port, one registered read port.
// Depends on nothing; instantiated three times by the core.
module tbg_store #(
  parameter int unsigned Depth = 600,
  parameter int unsigned Width = 12,
  parameter int unsigned IdxW  = 10
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/table_waveform_generator_core.sv
// Table waveform generator top level: keypad state, phase accumulator, output stages.
// Depends on tbg_pkg and tbg_store.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per transfer:
//   a sample tick, a key press or a table load. Key presses and loads update
//   state at the transfer and produce nothing. Each tick produces one
//   dac_code_o transfer on the output channel (out_valid_o/out_ready_i).
//   A tick's result passes the read stage, then the output register.
//   Throughput: one item per cycle unless stalled as below; the stores read
//   one entry per tick through a registered read port.
//   A read stage and an output register hold up to two results, so the block
//   keeps taking items while one result waits; it stops only when both hold
//   data and out_ready_i is low. No result is dropped or repeated.
//   Reset: square wave, duty 50, stride 1, phase 0, both square codes at
//   their defaults, pipeline empty. Store contents are undefined until
//   loaded. Configuration writes (cfg_we_i) take effect at once and are
//   expected only while no item is in flight.
module table_waveform_generator_core #(
  parameter int unsigned TableDepth = tbg_pkg::DepthDefault,
  parameter int unsigned SampleBits = tbg_pkg::SampleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tbg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbg_pkg::CodeW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tbg_pkg::OpW-1:0]      operation_i,
  input  logic [tbg_pkg::KeyW-1:0]     key_code_i,
  input  logic [tbg_pkg::SelW-1:0]     table_select_i,
  input  logic [tbg_pkg::AddrW-1:0]    table_address_i,
  input  logic [tbg_pkg::CodeW-1:0]    table_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tbg_pkg::CodeW-1:0]    dac_code_o
);

  localparam int unsigned IdxW   = $clog2(TableDepth);
  localparam int unsigned StoreW = (SampleBits < tbg_pkg::CodeW) ? SampleBits : tbg_pkg::CodeW;
  localparam int unsigned ProdW  = $clog2(128 * TableDepth);

  logic [tbg_pkg::CodeW-1:0]   sq_low_q, sq_low_d;
  logic [tbg_pkg::CodeW-1:0]   sq_high_q, sq_high_d;
  tbg_pkg::wave_e              wave_q, wave_d;
  logic [tbg_pkg::DutyW-1:0]   duty_q, duty_d;
  logic [tbg_pkg::StrideW-1:0] stride_q, stride_d;
  logic [IdxW-1:0]             phase_q, phase_d;

  logic                        s1_valid_q, s1_valid_d;
  tbg_pkg::wave_e              s1_wave_q;
  logic                        s1_high_q;
  logic                        out_valid_q, out_valid_d;
  logic [tbg_pkg::CodeW-1:0]   dac_code_q;
  logic [tbg_pkg::CodeW-1:0]   sample_code;

  logic                        s2_free, s1_move, accept, tick, key, load;
  logic                        addr_ok;
  logic [IdxW:0]               phase_sum;
  logic [ProdW-1:0]            phase_scaled, duty_scaled;
  logic                        square_high;
  logic [StoreW-1:0]           sine_rd, ramp_rd, tri_rd;

  assign s2_free    = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign accept     = in_valid_i && in_ready_o;
  assign tick       = accept && (operation_i == tbg_pkg::OP_TICK);
  assign key        = accept && (operation_i == tbg_pkg::OP_KEY);
  assign load       = accept && (operation_i == tbg_pkg::OP_LOAD);
  assign addr_ok    = {1'b0, table_address_i} < (tbg_pkg::AddrW + 1)'(TableDepth);

  assign phase_scaled = ProdW'(phase_q) * ProdW'(tbg_pkg::PctScale);
  assign duty_scaled  = ProdW'(duty_q) * ProdW'(TableDepth);
  assign square_high  = phase_scaled < duty_scaled;
  assign phase_sum    = {1'b0, phase_q} + (IdxW + 1)'(stride_q);

  tbg_store #(.Depth(TableDepth), .Width(StoreW), .IdxW(IdxW)) u_sine (
    .clk_i    (clk_i),
    .wr_en_i  (load && addr_ok && (table_select_i == tbg_pkg::SEL_SINE)),
    .wr_addr_i(table_address_i[IdxW-1:0]),
    .wr_data_i(table_data_i[StoreW-1:0]),
    .rd_en_i  (tick),
    .rd_addr_i(phase_q),
    .rd_data_o(sine_rd)
  );

  tbg_store #(.Depth(TableDepth), .Width(StoreW), .IdxW(IdxW)) u_ramp (
    .clk_i    (clk_i),
    .wr_en_i  (load && addr_ok && (table_select_i == tbg_pkg::SEL_RAMP)),
    .wr_addr_i(table_address_i[IdxW-1:0]),
    .wr_data_i(table_data_i[StoreW-1:0]),
    .rd_en_i  (tick),
    .rd_addr_i(phase_q),
    .rd_data_o(ramp_rd)
  );

  tbg_store #(.Depth(TableDepth), .Width(StoreW), .IdxW(IdxW)) u_tri (
    .clk_i    (clk_i),
    .wr_en_i  (load && addr_ok && (table_select_i == tbg_pkg::SEL_TRIANGLE)),
    .wr_addr_i(table_address_i[IdxW-1:0]),
    .wr_data_i(table_data_i[StoreW-1:0]),
    .rd_en_i  (tick),
    .rd_addr_i(phase_q),
    .rd_data_o(tri_rd)
  );

  always_comb begin
    sq_low_d  = sq_low_q;
    sq_high_d = sq_high_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tbg_pkg::CFG_SQ_LOW:  sq_low_d  = cfg_data_i;
        tbg_pkg::CFG_SQ_HIGH: sq_high_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    wave_d   = wave_q;
    duty_d   = duty_q;
    stride_d = stride_q;
    phase_d  = phase_q;
    if (tick) begin
      if (phase_sum >= (IdxW + 1)'(TableDepth)) begin
        phase_d = IdxW'(phase_sum - (IdxW + 1)'(TableDepth));
      end else begin
        phase_d = phase_sum[IdxW-1:0];
      end
    end else if (key) begin
      case (key_code_i)
        tbg_pkg::KEY_STRIDE1,
        tbg_pkg::KEY_STRIDE2,
        tbg_pkg::KEY_STRIDE3,
        tbg_pkg::KEY_STRIDE4,
        tbg_pkg::KEY_STRIDE5: stride_d = key_code_i[tbg_pkg::StrideW-1:0];
        tbg_pkg::KEY_SINE: begin
          wave_d   = tbg_pkg::WAVE_SINE;
          stride_d = tbg_pkg::StrideOne;
          phase_d  = '0;
        end
        tbg_pkg::KEY_TRIANGLE: begin
          wave_d   = tbg_pkg::WAVE_TRIANGLE;
          stride_d = tbg_pkg::StrideOne;
        end
        tbg_pkg::KEY_RAMP: begin
          wave_d   = tbg_pkg::WAVE_RAMP;
          stride_d = tbg_pkg::StrideOne;
          phase_d  = '0;
        end
        tbg_pkg::KEY_SQUARE: begin
          wave_d   = tbg_pkg::WAVE_SQUARE;
          duty_d   = tbg_pkg::DutyReset;
          stride_d = tbg_pkg::StrideOne;
          phase_d  = '0;
        end
        tbg_pkg::KEY_DUTY_RESET: begin
          if (wave_q == tbg_pkg::WAVE_SQUARE) begin
            duty_d = tbg_pkg::DutyReset;
          end
        end
        tbg_pkg::KEY_DUTY_DOWN: begin
          if (wave_q == tbg_pkg::WAVE_SQUARE && duty_q > tbg_pkg::DutyMin) begin
            duty_d = duty_q - tbg_pkg::DutyStep;
          end
        end
        tbg_pkg::KEY_DUTY_UP: begin
          if (wave_q == tbg_pkg::WAVE_SQUARE && duty_q < tbg_pkg::DutyMax) begin
            duty_d = duty_q + tbg_pkg::DutyStep;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (s1_wave_q)
      tbg_pkg::WAVE_SINE:     sample_code = tbg_pkg::CodeW'(sine_rd);
      tbg_pkg::WAVE_RAMP:     sample_code = tbg_pkg::CodeW'(ramp_rd);
      tbg_pkg::WAVE_TRIANGLE: sample_code = tbg_pkg::CodeW'(tri_rd);
      default:                sample_code = s1_high_q ? sq_high_q : sq_low_q;
    endcase
  end

  assign s1_valid_d  = tick || (s1_valid_q && !s2_free);
  assign out_valid_d = s1_move || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_low_q    <= tbg_pkg::SqLowReset;
      sq_high_q   <= tbg_pkg::SqHighReset;
      wave_q      <= tbg_pkg::WAVE_SQUARE;
      duty_q      <= tbg_pkg::DutyReset;
      stride_q    <= tbg_pkg::StrideOne;
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sq_low_q    <= sq_low_d;
      sq_high_q   <= sq_high_d;
      wave_q      <= wave_d;
      duty_q      <= duty_d;
      stride_q    <= stride_d;
      phase_q     <= phase_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      s1_wave_q <= wave_q;
      s1_high_q <= square_high;
    end
    if (s1_move) begin
      dac_code_q <= sample_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_code_o  = dac_code_q;

endmodule

### rtl/tbg_checker.sv
// Port-level checks for the table waveform generator, bound to the top level.
// Depends on tbg_pkg and table_waveform_generator_core.
module tbg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [tbg_pkg::OpW-1:0]     operation_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tbg_pkg::CodeW-1:0]   dac_code_o
);

  logic tick_xfer;
  assign tick_xfer = in_valid_i && in_ready_o && (operation_i == tbg_pkg::OP_TICK);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(dac_code_o))
    else $error("output code changed while stalled");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_xfer |-> ##2 out_valid_o)
    else $error("tick produced no result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(tick_xfer, 2))
    else $error("result appeared without a tick");

endmodule

bind table_waveform_generator_core tbg_checker u_tbg_checker (.*);
